>>> rtl/core/iolu_pkg.sv
// Package for the indexed ordered list unit: sizes, request and status codes,
// cell command and response structs, width conversion helpers. No dependencies.
`timescale 1ns / 1ps

package iolu_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	// fixed port widths
	localparam int OP_W   = 3;
	localparam int WORD_W = 32;
	localparam int POS_W  = 5;
	localparam int COUNT_W = 5;
	localparam int STAT_W = 3;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_INSERT     = 3'd4,
		OP_REMOVE     = 3'd5,
		OP_READ       = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_IGNORED = 3'd2,
		ST_FRONT   = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                  ins;
		logic                  del;
		logic [IDX_W-1:0]      at;
		logic [DATA_WIDTH-1:0] word;
		logic [IDX_W-1:0]      rd_at;
	} cell_cmd_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] count;
		logic             rd_en;
	} rsp_info_t;

	function automatic logic [DATA_WIDTH-1:0] word_to_data(input logic [WORD_W-1:0] w);
		logic [DATA_WIDTH-1:0] d;
		d = '0;
		for (int i = 0; i < DATA_WIDTH; i++) begin
			if (i < WORD_W) d[i] = w[i];
		end
		return d;
	endfunction

	function automatic logic [WORD_W-1:0] data_to_word(input logic [DATA_WIDTH-1:0] d);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (i < DATA_WIDTH) w[i] = d[i];
		end
		return w;
	endfunction

	function automatic logic [COUNT_W-1:0] cnt_to_port(input logic [CNT_W-1:0] c);
		logic [COUNT_W-1:0] p;
		p = '0;
		for (int i = 0; i < COUNT_W; i++) begin
			if (i < CNT_W) p[i] = c[i];
		end
		return p;
	endfunction

endpackage

>>> rtl/core/iolu_if.sv
// Valid/ready channel interfaces for the list unit: request and response.
// Depends on iolu_pkg for the fixed field widths.
`timescale 1ns / 1ps

interface iolu_req_if;
	logic                        valid;
	logic                        ready;
	logic [iolu_pkg::OP_W-1:0]   operation;
	logic [iolu_pkg::WORD_W-1:0] item_value;
	logic [iolu_pkg::POS_W-1:0]  position;

	modport source(output valid, operation, item_value, position, input ready);
	modport sink(input valid, operation, item_value, position, output ready);
endinterface

interface iolu_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [iolu_pkg::WORD_W-1:0]  read_value;
	logic [iolu_pkg::COUNT_W-1:0] element_count;
	logic [iolu_pkg::STAT_W-1:0]  status;

	modport source(output valid, read_value, element_count, status, input ready);
	modport sink(input valid, read_value, element_count, status, output ready);
endinterface

>>> rtl/core/iolu_cell.sv
// One storage cell of the list chain: holds one word, shifts from a neighbor,
// loads the new word or holds. Depends on iolu_pkg.
`timescale 1ns / 1ps

module iolu_cell (
	input  logic                            clk,
	input  iolu_pkg::cell_cmd_t             cmd,
	input  logic [iolu_pkg::IDX_W-1:0]      my_index,
	input  logic [iolu_pkg::DATA_WIDTH-1:0] left_data,
	input  logic [iolu_pkg::DATA_WIDTH-1:0] right_data,
	output logic [iolu_pkg::DATA_WIDTH-1:0] data_q,
	output logic [iolu_pkg::DATA_WIDTH-1:0] rd_data
);
	import iolu_pkg::*;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (my_index == cmd.at) begin
				data_q <= cmd.word;
			end else if (my_index > cmd.at) begin
				data_q <= left_data;
			end
		end else if (cmd.del && (my_index >= cmd.at)) begin
			data_q <= right_data;
		end
	end

	// wired-OR read bus: only the addressed cell drives nonzero
	assign rd_data = (my_index == cmd.rd_at) ? data_q : '0;

endmodule

>>> rtl/core/iolu_ctrl.sv
// Request decode and element count for the list unit. Builds the command that
// every cell sees and the response info. Depends on iolu_pkg.
`timescale 1ns / 1ps

module iolu_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [iolu_pkg::OP_W-1:0]    operation,
	input  logic [iolu_pkg::WORD_W-1:0]  item_value,
	input  logic [iolu_pkg::POS_W-1:0]   position,
	output iolu_pkg::cell_cmd_t          cmd,
	output iolu_pkg::rsp_info_t          info
);
	import iolu_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] cnt_idx;
	logic             full;
	logic             empty;
	logic             pos_lt;
	logic             ins;
	logic             del;
	op_t              op;

	assign op      = op_t'(operation);
	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign pos_idx = pos_ext[IDX_W-1:0];
	assign cnt_idx = cnt_ext[IDX_W-1:0];
	assign full    = (cnt_ext == CMP_W'(CAPACITY));
	assign empty   = (count_q == '0);
	assign pos_lt  = (pos_ext < cnt_ext);

	always_comb begin
		ins         = 1'b0;
		del         = 1'b0;
		cmd.at      = '0;
		cmd.rd_at   = '0;
		cmd.word    = word_to_data(item_value);
		info.status = ST_OK;
		info.rd_en  = 1'b0;
		count_nxt   = count_q;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
				if (full) begin
					info.status = ST_FULL;
				end else begin
					ins       = 1'b1;
					count_nxt = count_q + 1'b1;
					if (op == OP_PUSH_FRONT || (op == OP_INSERT && position == '0)) begin
						cmd.at = '0;
					end else if (op == OP_PUSH_BACK || !pos_lt) begin
						cmd.at = cnt_idx;
					end else begin
						cmd.at = pos_idx;
					end
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					info.status = ST_IGNORED;
				end else begin
					del       = 1'b1;
					cmd.at    = '0;
					count_nxt = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					info.status = ST_IGNORED;
				end else begin
					count_nxt = count_q - 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!pos_lt) begin
					info.status = ST_IGNORED;
				end else begin
					del       = 1'b1;
					cmd.at    = pos_idx;
					count_nxt = count_q - 1'b1;
				end
			end
			OP_READ: begin
				if (empty) begin
					info.status = ST_EMPTY;
				end else if (!pos_lt) begin
					info.status = ST_FRONT;
					info.rd_en  = 1'b1;
				end else begin
					info.rd_en = 1'b1;
					cmd.rd_at  = pos_idx;
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
		cmd.ins    = ins & fire;
		cmd.del    = del & fire;
		info.count = count_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_nxt;
		end
	end

endmodule

>>> rtl/core/indexed_ordered_list_unit.sv
// Indexed ordered list unit, top level: decode, chain of storage cells, response register.
// Depends on iolu_pkg, iolu_if, iolu_ctrl and iolu_cell.
// A bounded ordered list of up to CAPACITY words (push/pop at either end, insert,
// remove and read at an index, clear). One request is accepted per clock; its
// response appears in the response register on the next cycle and the next request
// is taken in the same cycle as long as the response register is empty or being
// drained. Every cell of the chain compares its own index with the request index and
// shifts from its left or right neighbor, loads the new word, or holds, all in the
// accepting cycle, so insert and remove finish in that cycle regardless of position. The
// request ready drops only while a response is held by the downstream side.
`timescale 1ns / 1ps

module indexed_ordered_list_unit (
	input  logic       clk,
	input  logic       arst_n,
	iolu_req_if.sink   req,
	iolu_rsp_if.source rsp
);
	import iolu_pkg::*;

	cell_cmd_t             cmd;
	rsp_info_t             info;
	logic                  fire;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_bus;

	logic                  rsp_valid_q;
	logic [WORD_W-1:0]     read_value_q;
	logic [COUNT_W-1:0]    count_q;
	status_t               status_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	iolu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.operation  (req.operation),
		.item_value (req.item_value),
		.position   (req.position),
		.cmd        (cmd),
		.info       (info)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = cell_data[i];
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		iolu_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.my_index   (IDX_W'(i)),
			.left_data  (left_w),
			.right_data (right_w),
			.data_q     (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_value_q <= info.rd_en ? data_to_word(rd_bus) : '0;
			count_q      <= cnt_to_port(info.count);
			status_q     <= info.status;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_value    = read_value_q;
	assign rsp.element_count = count_q;
	assign rsp.status        = status_q;

endmodule

>>> rtl/core/iolu_checker.sv
// Port-level checks for the indexed ordered list unit, bound to the top level.
// Depends on iolu_pkg for sizes and status codes.
`timescale 1ns / 1ps

module iolu_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [iolu_pkg::WORD_W-1:0]  read_value,
	input logic [iolu_pkg::COUNT_W-1:0] element_count,
	input logic [iolu_pkg::STAT_W-1:0]  status
);
	import iolu_pkg::*;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(element_count) <= CAPACITY))
		else $error("element count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_FULL) |-> (32'(element_count) == CAPACITY))
		else $error("full drop reported on a list that is not full");

	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_EMPTY) |-> (element_count == '0 && read_value == '0))
		else $error("empty read with nonzero count or data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(element_count) && $stable(status)))
		else $error("stalled response word changed");

endmodule

bind indexed_ordered_list_unit iolu_checker u_iolu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.read_value    (rsp.read_value),
	.element_count (rsp.element_count),
	.status        (rsp.status)
);
